@@ rtl/core/ptt_seq_pkg.sv @@
package ptt_seq_pkg;

    localparam int TIMER_BITS = 16;
    localparam int DAC_BITS   = 12;

    localparam int HOLD_W  = 16;
    localparam int BIAS_W  = 12;
    localparam int BLINK_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST = HOLD_W'(100);
    localparam logic [BIAS_W-1:0]  TX_BIAS_RST    = '0;
    localparam logic [BLINK_W-1:0] BLINK_HALF_RST = BLINK_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLD_TICKS = 2'd0,
        REG_TX_BIAS    = 2'd1,
        REG_BLINK_HALF = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MODE_RX        = 3'd0,
        MODE_LNA_OFF   = 3'd1,
        MODE_PRE_DRIVE = 3'd2,
        MODE_TX        = 3'd3,
        MODE_AMP_OFF   = 3'd4,
        MODE_ESTOP     = 3'd5
    } mode_t;

    typedef struct packed {
        logic [HOLD_W-1:0]  hold_ticks;
        logic [BIAS_W-1:0]  tx_bias;
        logic [BLINK_W-1:0] blink_half_period;
    } cfg_t;

endpackage

@@ rtl/core/ptt_tx_rx_sequencer_unit.sv @@
// Transmit/receive sequencer for an amplifier bias controller. Each input
// transfer is one millisecond tick carrying the PTT level and the overcurrent
// alert; each tick yields one output transfer with the mode and the levels
// after the tick. The block takes one tick per clock cycle while m_tready
// holds no output back: the tick is registered, the mode, hold timer and
// blink counter update in a single combinational step, and the result sits
// in an output register. Configuration writes (hold_ticks, tx_bias,
// blink_half_period) are taken every cycle and belong in idle periods.
module ptt_tx_rx_sequencer_unit
    import ptt_seq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] ptt_in, [1] overcurrent_alert
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [2:0] mode_code, [3] ptt_out, [4] led_on,
                                             // [16:5] gate_bias, [17] pa_shutdown
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t        cfg;
    logic [2:0]  mode_code;
    logic        ptt_out;
    logic        led_on;
    logic [11:0] gate_bias;
    logic        pa_shutdown;

    ptt_seq_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ptt_seq_core u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .ptt_in            (s_tdata[0]),
        .overcurrent_alert (s_tdata[1]),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .mode_code         (mode_code),
        .ptt_out           (ptt_out),
        .led_on            (led_on),
        .gate_bias         (gate_bias),
        .pa_shutdown       (pa_shutdown)
    );

    assign m_tdata = {6'b0, pa_shutdown, gate_bias, led_on, ptt_out, mode_code};

endmodule

@@ rtl/core/ptt_seq_regs.sv @@
module ptt_seq_regs
    import ptt_seq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_HOLD_TICKS: cfg_next.hold_ticks        = HOLD_W'(cfg_data);
                REG_TX_BIAS:    cfg_next.tx_bias           = cfg_data[BIAS_W-1:0];
                REG_BLINK_HALF: cfg_next.blink_half_period = BLINK_W'(cfg_data);
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ticks        <= HOLD_TICKS_RST;
            cfg_reg.tx_bias           <= TX_BIAS_RST;
            cfg_reg.blink_half_period <= BLINK_HALF_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/core/ptt_seq_core.sv @@
module ptt_seq_core
    import ptt_seq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        ptt_in,
    input  logic        overcurrent_alert,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  mode_code,
    output logic        ptt_out,
    output logic        led_on,
    output logic [11:0] gate_bias,
    output logic        pa_shutdown
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic                  ptt_reg;
    logic                  alert_reg;
    logic                  advance;

    mode_t                 mode_reg;
    mode_t                 mode_next;
    logic [TIMER_BITS-1:0] hold_count_reg;
    logic [TIMER_BITS-1:0] hold_count_next;
    logic                  ptt_out_level_reg;
    logic                  ptt_out_level_next;
    logic                  led_level_reg;
    logic                  led_level_next;
    logic [DAC_BITS-1:0]   bias_level_reg;
    logic [DAC_BITS-1:0]   bias_level_next;
    logic [BLINK_W-1:0]    blink_count_reg;
    logic [BLINK_W-1:0]    blink_count_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [2:0]            mode_code_reg;
    logic                  ptt_out_reg;
    logic                  led_on_reg;
    logic [11:0]           gate_bias_reg;
    logic                  pa_shutdown_reg;

    logic                  expired;
    logic                  enter;
    mode_t                 target;
    logic [TIMER_BITS-1:0] hold_load;

    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign in_valid_next  = (s_tvalid && s_tready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);
    assign expired        = (hold_count_reg <= TIMER_BITS'(1));
    assign hold_load      = TIMER_BITS'(cfg.hold_ticks);

    always_comb
    begin
        enter  = 1'b0;
        target = mode_reg;
        case (mode_reg)
            MODE_RX:
            begin
                enter  = ptt_reg;
                target = MODE_LNA_OFF;
            end
            MODE_LNA_OFF:
            begin
                enter  = expired;
                target = ptt_reg ? MODE_PRE_DRIVE : MODE_RX;
            end
            MODE_PRE_DRIVE:
            begin
                enter  = expired;
                target = ptt_reg ? MODE_TX : MODE_AMP_OFF;
            end
            MODE_TX:
            begin
                enter  = !ptt_reg;
                target = MODE_AMP_OFF;
            end
            default:
            begin
                enter  = expired;
                target = ptt_reg ? MODE_TX : MODE_RX;
            end
        endcase
    end

    always_comb
    begin
        mode_next          = mode_reg;
        hold_count_next    = hold_count_reg;
        ptt_out_level_next = ptt_out_level_reg;
        led_level_next     = led_level_reg;
        bias_level_next    = bias_level_reg;
        blink_count_next   = blink_count_reg;
        if (advance)
        begin
            if (mode_reg == MODE_ESTOP)
            begin
                if (blink_count_reg <= BLINK_W'(1))
                begin
                    led_level_next   = !led_level_reg;
                    blink_count_next = cfg.blink_half_period;
                end
                else
                begin
                    blink_count_next = blink_count_reg - BLINK_W'(1);
                end
            end
            else if (alert_reg)
            begin
                mode_next          = MODE_ESTOP;
                bias_level_next    = '0;
                ptt_out_level_next = 1'b0;
                blink_count_next   = cfg.blink_half_period;
            end
            else
            begin
                if (!expired && mode_reg != MODE_RX && mode_reg != MODE_TX)
                begin
                    hold_count_next = hold_count_reg - TIMER_BITS'(1);
                end
                if (enter)
                begin
                    mode_next = target;
                    case (target)
                        MODE_LNA_OFF:
                        begin
                            hold_count_next = hold_load;
                        end
                        MODE_PRE_DRIVE:
                        begin
                            ptt_out_level_next = 1'b1;
                            hold_count_next    = hold_load;
                        end
                        MODE_TX:
                        begin
                            bias_level_next = DAC_BITS'(cfg.tx_bias);
                            led_level_next  = 1'b1;
                        end
                        MODE_AMP_OFF:
                        begin
                            led_level_next     = 1'b0;
                            ptt_out_level_next = 1'b0;
                            bias_level_next    = '0;
                            hold_count_next    = hold_load;
                        end
                        default:
                        begin
                            mode_next = target;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            mode_reg          <= MODE_AMP_OFF;
            hold_count_reg    <= TIMER_BITS'(HOLD_TICKS_RST);
            ptt_out_level_reg <= 1'b0;
            led_level_reg     <= 1'b0;
            bias_level_reg    <= '0;
            blink_count_reg   <= '0;
        end
        else
        begin
            in_valid_reg      <= in_valid_next;
            out_valid_reg     <= out_valid_next;
            mode_reg          <= mode_next;
            hold_count_reg    <= hold_count_next;
            ptt_out_level_reg <= ptt_out_level_next;
            led_level_reg     <= led_level_next;
            bias_level_reg    <= bias_level_next;
            blink_count_reg   <= blink_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ptt_reg   <= ptt_in;
            alert_reg <= overcurrent_alert;
        end
        if (advance)
        begin
            mode_code_reg   <= mode_next;
            ptt_out_reg     <= ptt_out_level_next;
            led_on_reg      <= led_level_next;
            gate_bias_reg   <= 12'(bias_level_next);
            pa_shutdown_reg <= (mode_next == MODE_ESTOP);
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign mode_code   = mode_code_reg;
    assign ptt_out     = ptt_out_reg;
    assign led_on      = led_on_reg;
    assign gate_bias   = gate_bias_reg;
    assign pa_shutdown = pa_shutdown_reg;

    a_estop_latched: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_ESTOP |=> mode_reg == MODE_ESTOP)
        else $error("emergency stop left without reset");

    a_estop_safe: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_ESTOP |-> (bias_level_reg == '0 && !ptt_out_level_reg))
        else $error("bias or keying active in emergency stop");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(mode_reg) && $stable(hold_count_reg))
        else $error("sequencer state moved without a transfer");

    a_keying_mode: assert property (@(posedge clk) disable iff (!rst_n)
        ptt_out_level_reg |-> (mode_reg == MODE_PRE_DRIVE || mode_reg == MODE_TX))
        else $error("keying output high outside pre-drive and tx");

endmodule

@@ tb/ptt_tx_rx_sequencer_unit_tb.sv @@
module ptt_tx_rx_sequencer_unit_tb;
    import ptt_seq_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        mode_t              mode;
        logic               ptt_out;
        logic               led_on;
        logic [BIAS_W-1:0]  gate_bias;
        logic               pa_shutdown;
    } status_t;

    typedef struct packed {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] wdata;
        logic                  ptt;
        logic                  alert;
        logic [7:0]            reps;
        logic                  typed;
        status_t               want;
    } step_row_t;

    localparam status_t NO_STATUS    = '{MODE_RX, 1'b0, 1'b0, 12'h000, 1'b0};
    localparam status_t RX_IDLE      = '{MODE_RX, 1'b0, 1'b0, 12'h000, 1'b0};
    localparam status_t AMP_OFF_IDLE = '{MODE_AMP_OFF, 1'b0, 1'b0, 12'h000, 1'b0};
    localparam status_t LNA_IDLE     = '{MODE_LNA_OFF, 1'b0, 1'b0, 12'h000, 1'b0};
    localparam status_t PRE_KEYED    = '{MODE_PRE_DRIVE, 1'b1, 1'b0, 12'h000, 1'b0};
    localparam status_t TX_COLD_FULL = '{MODE_TX, 1'b0, 1'b1, 12'hFFF, 1'b0};
    localparam status_t TX_COLD_123  = '{MODE_TX, 1'b0, 1'b1, 12'h123, 1'b0};
    localparam status_t TX_KEYED_123 = '{MODE_TX, 1'b1, 1'b1, 12'h123, 1'b0};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int send_idle_pct = 23;
    int recv_idle_pct = 45;
    int err_count     = 0;

    logic [HOLD_W-1:0]  hold_ticks_q;
    logic [BIAS_W-1:0]  tx_bias_q;
    logic [BLINK_W-1:0] blink_half_q;

    mode_t              seq_mode;
    logic [HOLD_W-1:0]  hold_cnt;
    logic               key_lvl;
    logic               led_lvl;
    logic [BIAS_W-1:0]  bias_lvl;
    logic [BLINK_W-1:0] blink_cnt;

    status_t   status_due [$];
    step_row_t plan [30];

    ptt_tx_rx_sequencer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    function automatic logic hold_expired();
        if (hold_cnt <= 1)
            return 1'b1;
        hold_cnt = hold_cnt - 1'b1;
        return 1'b0;
    endfunction

    function automatic void enter_state(input mode_t nxt);
        seq_mode = nxt;
        case (nxt)
            MODE_LNA_OFF:
                hold_cnt = hold_ticks_q;
            MODE_PRE_DRIVE:
            begin
                key_lvl  = 1'b1;
                hold_cnt = hold_ticks_q;
            end
            MODE_TX:
            begin
                bias_lvl = tx_bias_q;
                led_lvl  = 1'b1;
            end
            MODE_AMP_OFF:
            begin
                led_lvl  = 1'b0;
                key_lvl  = 1'b0;
                bias_lvl = '0;
                hold_cnt = hold_ticks_q;
            end
            default: ;
        endcase
    endfunction

    function automatic status_t advance_sequencer(input logic ptt, input logic alert);
        status_t s;
        if (seq_mode == MODE_ESTOP)
        begin
            if (blink_cnt <= 1)
            begin
                led_lvl   = ~led_lvl;
                blink_cnt = blink_half_q;
            end
            else
                blink_cnt = blink_cnt - 1'b1;
        end
        else if (alert)
        begin
            seq_mode  = MODE_ESTOP;
            bias_lvl  = '0;
            key_lvl   = 1'b0;
            blink_cnt = blink_half_q;
        end
        else
        begin
            case (seq_mode)
                MODE_RX:
                    if (ptt)
                        enter_state(MODE_LNA_OFF);
                MODE_LNA_OFF:
                    if (hold_expired())
                        enter_state(ptt ? MODE_PRE_DRIVE : MODE_RX);
                MODE_PRE_DRIVE:
                    if (hold_expired())
                        enter_state(ptt ? MODE_TX : MODE_AMP_OFF);
                MODE_TX:
                    if (!ptt)
                        enter_state(MODE_AMP_OFF);
                default:
                    if (hold_expired())
                        enter_state(ptt ? MODE_TX : MODE_RX);
            endcase
        end
        s.mode        = seq_mode;
        s.ptt_out     = key_lvl;
        s.led_on      = led_lvl;
        s.gate_bias   = bias_lvl;
        s.pa_shutdown = (seq_mode == MODE_ESTOP);
        return s;
    endfunction

    // drop valid and hold until every tick has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (status_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_HOLD_TICKS: hold_ticks_q = data;
            REG_TX_BIAS:    tx_bias_q    = data[BIAS_W-1:0];
            REG_BLINK_HALF: blink_half_q = data;
            default: ;
        endcase
    endtask

    task automatic send_tick(input logic ptt, input logic alert,
                             input logic typed, input status_t want);
        status_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, alert, ptt};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = advance_sequencer(ptt, alert);
        status_due.push_back(typed ? want : predicted);
    endtask

    // hold PTT in runs around the hold time (capped at 20 ticks), with single-tick glitches
    task automatic random_ticks(input int count, input int alert_pct);
        int   left;
        int   span;
        logic level;
        left  = 0;
        level = 1'b0;
        span  = (hold_ticks_q > 20) ? 20 : int'(hold_ticks_q);
        repeat (count)
        begin
            if (left == 0)
            begin
                level = ~level;
                left  = $urandom_range(1, 2 * span + 3);
            end
            left--;
            send_tick(($urandom_range(0, 9) == 0) ? ~level : level,
                      $urandom_range(0, 99) < alert_pct, 1'b0, NO_STATUS);
        end
    endtask

    always @(posedge clk)
    begin : watch
        status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (status_due.size() == 0)
                report_mismatch("transfer with nothing pending", m_tdata, 0);
            else
            begin
                want = status_due.pop_front();
                if (m_tdata[2:0] !== want.mode)
                    report_mismatch("mode_code", m_tdata[2:0], want.mode);
                if (m_tdata[3] !== want.ptt_out)
                    report_mismatch("ptt_out", m_tdata[3], want.ptt_out);
                if (m_tdata[4] !== want.led_on)
                    report_mismatch("led_on", m_tdata[4], want.led_on);
                if (m_tdata[16:5] !== want.gate_bias)
                    report_mismatch("gate_bias", m_tdata[16:5], want.gate_bias);
                if (m_tdata[17] !== want.pa_shutdown)
                    report_mismatch("pa_shutdown", m_tdata[17], want.pa_shutdown);
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        #20000000;
        $display("** ptt_tx_rx_sequencer_unit: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int ph;
        hold_ticks_q = HOLD_TICKS_RST;
        tx_bias_q    = TX_BIAS_RST;
        blink_half_q = BLINK_HALF_RST;
        seq_mode     = MODE_AMP_OFF;
        hold_cnt     = HOLD_TICKS_RST;
        key_lvl      = 1'b0;
        led_lvl      = 1'b0;
        bias_lvl     = '0;
        blink_cnt    = '0;

        // write, index, data, ptt, alert, ticks, typed, expected
        plan = '{
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b0, 1'b0, 8'd1,  1'b1, AMP_OFF_IDLE},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b0, 1'b0, 8'd1,  1'b1, AMP_OFF_IDLE},
            '{1'b1, REG_HOLD_TICKS, 16'h0001, 1'b0, 1'b0, 8'd0,  1'b0, NO_STATUS},
            '{1'b1, REG_TX_BIAS,    16'hFFFF, 1'b0, 1'b0, 8'd0,  1'b0, NO_STATUS},
            '{1'b1, REG_BLINK_HALF, 16'h0001, 1'b0, 1'b0, 8'd0,  1'b0, NO_STATUS},
            '{1'b1, REG_SPARE,      16'hFFFF, 1'b0, 1'b0, 8'd0,  1'b0, NO_STATUS},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b1, 1'b0, 8'd98, 1'b0, NO_STATUS},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b1, 1'b0, 8'd1,  1'b1, TX_COLD_FULL},
            '{1'b1, REG_TX_BIAS,    16'h0123, 1'b0, 1'b0, 8'd0,  1'b0, NO_STATUS},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b1, 1'b0, 8'd1,  1'b1, TX_COLD_FULL},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b0, 1'b0, 8'd1,  1'b1, AMP_OFF_IDLE},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b0, 1'b0, 8'd1,  1'b1, RX_IDLE},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b0, 1'b0, 8'd1,  1'b1, RX_IDLE},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b1, 1'b0, 8'd1,  1'b1, LNA_IDLE},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b1, 1'b0, 8'd1,  1'b1, PRE_KEYED},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b1, 1'b0, 8'd1,  1'b1, TX_KEYED_123},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b0, 1'b0, 8'd1,  1'b1, AMP_OFF_IDLE},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b1, 1'b0, 8'd1,  1'b1, TX_COLD_123},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b0, 1'b0, 8'd1,  1'b0, NO_STATUS},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b0, 1'b0, 8'd1,  1'b0, NO_STATUS},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b1, 1'b0, 8'd1,  1'b0, NO_STATUS},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b0, 1'b0, 8'd1,  1'b0, NO_STATUS},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b1, 1'b0, 8'd2,  1'b0, NO_STATUS},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b0, 1'b0, 8'd1,  1'b0, NO_STATUS},
            '{1'b1, REG_HOLD_TICKS, 16'h0000, 1'b0, 1'b0, 8'd0,  1'b0, NO_STATUS},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b1, 1'b0, 8'd1,  1'b0, NO_STATUS},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b0, 1'b0, 8'd2,  1'b0, NO_STATUS},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b1, 1'b0, 8'd3,  1'b0, NO_STATUS},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b0, 1'b0, 8'd2,  1'b0, NO_STATUS},
            '{1'b0, REG_HOLD_TICKS, 16'h0000, 1'b1, 1'b0, 8'd4,  1'b0, NO_STATUS}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_write)
                write_reg(plan[i].reg_idx, plan[i].wdata);
            else
                repeat (plan[i].reps)
                    send_tick(plan[i].ptt, plan[i].alert, plan[i].typed, plan[i].want);
        end

        for (ph = 0; ph < 6; ph++)
        begin
            send_idle_pct = (ph < 2) ? 23 : (ph < 4) ? 45 : 0;
            recv_idle_pct = (ph < 2) ? 45 : (ph < 4) ? 23 : 0;
            write_reg(REG_HOLD_TICKS, (ph == 0) ? 16'd1 : 16'($urandom_range(1, 8)));
            write_reg(REG_TX_BIAS, (ph == 1) ? 16'h0000 :
                                   (ph == 2) ? 16'h0FFF : 16'($urandom_range(0, 65535)));
            write_reg(REG_BLINK_HALF, 16'($urandom_range(0, 65535)));
            random_ticks(300, 0);
        end

        // stretch a timed state with the longest hold, then trip the alarm
        write_reg(REG_HOLD_TICKS, 16'hFFFF);
        random_ticks(40, 0);
        send_idle_pct = 23;
        recv_idle_pct = 45;
        write_reg(REG_BLINK_HALF, 16'h0001);
        random_ticks(40, 25);
        write_reg(REG_BLINK_HALF, 16'h0000);
        random_ticks(30, 50);
        write_reg(REG_BLINK_HALF, 16'h0003);
        write_reg(REG_TX_BIAS, 16'h0FFF);
        random_ticks(40, 50);
        write_reg(REG_BLINK_HALF, 16'hFFFF);
        random_ticks(10, 50);

        settle();
        repeat (4) @(posedge clk);
        if (status_due.size() != 0)
            report_mismatch("results never delivered", 0, status_due.size());
        if (err_count == 0)
            $display("** ptt_tx_rx_sequencer_unit: PASSED **");
        else
            $display("** ptt_tx_rx_sequencer_unit: FAILED **");
        $finish;
    end

endmodule
